>>> hw/rtl/mersenne_twister_generator_macros.svh
// Assertion macros for the MT19937 generator checker.
// Used by mtg_checker.sv; expects clk and rst in scope.
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// property holds in the same cycle
`define MTG_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mtg_pkg.sv
// Shared types, constants and functions of the MT19937 generator.
// No dependencies.
package mtg_pkg;

  localparam int STATE_WORDS = 624;
  localparam int TAP_OFFSET  = 397;
  localparam int IDX_W       = 10;
  localparam int WORD_W      = 32;

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;

  localparam logic [1:0] MODE_DRAW  = 2'd0;
  localparam logic [1:0] MODE_RANGE = 2'd1;
  localparam logic [1:0] MODE_SEED  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  typedef enum logic [1:0] {REQ_DRAW, REQ_RANGE, REQ_SEED, REQ_ZERO} req_kind_t;
  typedef enum logic [1:0] {RD_K, RD_K1, RD_TAP, RD_IDX} rd_sel_t;

  typedef enum logic [3:0] {
    S_SEED_GO, S_SEED_MUL, S_SEED_WR, S_IDLE,
    S_TW_A, S_TW_B, S_TW_C, S_TW_D,
    S_DR_RD, S_DR_CAP, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic    take;
    logic    seed_start;
    logic    seed_dflt;
    logic    seed_mul;
    logic    seed_wr;
    logic    tw_start;
    rd_sel_t rd_sel;
    logic    cap_hi;
    logic    cap_lo;
    logic    tw_wr;
    logic    draw_cap;
    logic    div_step;
  } mtg_cmd_t;

  typedef struct packed {
    req_kind_t req_kind;
    req_kind_t cur_kind;
    logic      idx_full;
    logic      k_last;
    logic      div_last;
  } mtg_stat_t;

  function automatic req_kind_t decode_kind(input logic [1:0] mode,
                                            input logic [31:0] range_max);
    req_kind_t kind;
    case (mode)
      MODE_DRAW:  kind = REQ_DRAW;
      MODE_RANGE: kind = (range_max != 32'd0) ? REQ_RANGE : REQ_ZERO;
      MODE_SEED:  kind = REQ_SEED;
      default:    kind = REQ_ZERO;
    endcase
    return kind;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

>>> hw/rtl/mtg_in_if.sv
// Request channel of the MT19937 generator.
// No dependencies.
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] seed_value;
  logic [31:0] range_max;

  modport source (output valid, mode, seed_value, range_max, input ready);
  modport sink (input valid, mode, seed_value, range_max, output ready);
endinterface

>>> hw/rtl/mtg_out_if.sv
// Result channel of the MT19937 generator.
// No dependencies.
interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

>>> hw/rtl/mtg_datapath.sv
// Datapath: state memory, seeding multiplier, twist, tempering, divider.
// Depends on mtg_pkg; driven by mtg_ctrl commands.
module mtg_datapath
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mtg_cmd_t    cmd,
  output mtg_stat_t   stat,
  input  logic [1:0]  mode,
  input  logic [31:0] seed_value,
  input  logic [31:0] range_max,
  output logic [31:0] value
);

  logic [31:0] mem [0:STATE_WORDS-1];
  logic [31:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  req_kind_t   cur_kind;
  logic [31:0] seed_q;
  logic [31:0] bound;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] read_index;
  logic [31:0] p;
  logic [31:0] prod;
  logic [31:0] hi_w;
  logic [31:0] lo_w;
  logic [31:0] rem;
  logic [31:0] dvd;

  logic [IDX_W-1:0] k1;
  logic [IDX_W:0]   tap_sum;
  logic [IDX_W-1:0] tap;
  logic [31:0]      seed_src;
  logic [31:0]      seed_nw;
  logic [31:0]      mix;
  logic [31:0]      tw_nw;
  logic [32:0]      shifted;
  logic [32:0]      trial;
  logic [31:0]      rem_next;
  logic [31:0]      tempered;

  assign k1       = (k == IDX_W'(STATE_WORDS - 1)) ? '0 : k + 1'b1;
  assign tap_sum  = {1'b0, k} + (IDX_W+1)'(TAP_OFFSET);
  assign tap      = (tap_sum >= (IDX_W+1)'(STATE_WORDS)) ?
                    IDX_W'(tap_sum - (IDX_W+1)'(STATE_WORDS)) : IDX_W'(tap_sum);
  assign seed_src = cmd.seed_dflt ? DEFAULT_SEED : seed_q;
  assign seed_nw  = prod + 32'(k);
  assign mix      = {hi_w[31], lo_w[30:0]};
  assign tw_nw    = rd_data ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : 32'd0);
  assign shifted  = {rem, dvd[31]};
  assign trial    = shifted - {1'b0, bound};
  assign rem_next = trial[32] ? shifted[31:0] : trial[31:0];
  assign tempered = temper(rd_data);

  always_comb begin
    case (cmd.rd_sel)
      RD_K:    rd_addr = k;
      RD_K1:   rd_addr = k1;
      RD_TAP:  rd_addr = tap;
      RD_IDX:  rd_addr = read_index;
      default: rd_addr = k;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k;
    wr_data = tw_nw;
    if (cmd.seed_start) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = seed_src;
    end else if (cmd.seed_wr) begin
      wr_en   = 1'b1;
      wr_data = seed_nw;
    end else if (cmd.tw_wr) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index <= IDX_W'(STATE_WORDS);
      cur_kind   <= REQ_ZERO;
    end else begin
      if (cmd.take) begin
        cur_kind <= decode_kind(mode, range_max);
      end
      if (cmd.seed_wr && k == IDX_W'(STATE_WORDS - 1)) begin
        read_index <= IDX_W'(STATE_WORDS);
      end else if (cmd.tw_wr && k == IDX_W'(STATE_WORDS - 1)) begin
        read_index <= '0;
      end else if (cmd.draw_cap) begin
        read_index <= read_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      seed_q <= seed_value;
      bound  <= range_max;
      value  <= '0;
    end
    if (cmd.seed_start) begin
      p <= seed_src;
      k <= IDX_W'(1);
    end
    if (cmd.seed_mul) begin
      prod <= 32'(SEED_MULT * (p ^ (p >> 30)));
    end
    if (cmd.seed_wr) begin
      p <= seed_nw;
      k <= k + 1'b1;
    end
    if (cmd.tw_start) begin
      k <= '0;
    end
    if (cmd.cap_hi) begin
      hi_w <= rd_data;
    end
    if (cmd.cap_lo) begin
      lo_w <= rd_data;
    end
    if (cmd.tw_wr) begin
      k <= k + 1'b1;
    end
    if (cmd.draw_cap) begin
      value <= tempered;
      dvd   <= tempered;
      rem   <= '0;
      k     <= '0;
    end
    if (cmd.div_step) begin
      rem   <= rem_next;
      value <= rem_next;
      dvd   <= dvd << 1;
      k     <= k + 1'b1;
    end
  end

  assign stat.req_kind = decode_kind(mode, range_max);
  assign stat.cur_kind = cur_kind;
  assign stat.idx_full = (read_index == IDX_W'(STATE_WORDS));
  assign stat.k_last   = (k == IDX_W'(STATE_WORDS - 1));
  assign stat.div_last = (k == IDX_W'(WORD_W - 1));

endmodule

>>> hw/rtl/mtg_ctrl.sv
// Controller state machine of the MT19937 generator.
// Depends on mtg_pkg; sequences mtg_datapath.
module mtg_ctrl
  import mtg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  mtg_stat_t stat,
  output mtg_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   reply;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SEED_GO;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take) begin
        reply <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_K;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_SEED_GO: begin
        cmd.seed_start = 1'b1;
        cmd.seed_dflt  = !reply;
        state_next     = S_SEED_MUL;
      end
      S_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next   = S_SEED_WR;
      end
      S_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        if (stat.k_last) begin
          state_next = reply ? S_OUT : S_IDLE;
        end else begin
          state_next = S_SEED_MUL;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          case (stat.req_kind)
            REQ_DRAW, REQ_RANGE: begin
              if (stat.idx_full) begin
                cmd.tw_start = 1'b1;
                state_next   = S_TW_A;
              end else begin
                state_next = S_DR_RD;
              end
            end
            REQ_SEED: state_next = S_SEED_GO;
            default:  state_next = S_OUT;
          endcase
        end
      end
      S_TW_A: begin
        cmd.rd_sel = RD_K;
        state_next = S_TW_B;
      end
      S_TW_B: begin
        cmd.rd_sel = RD_K1;
        cmd.cap_hi = 1'b1;
        state_next = S_TW_C;
      end
      S_TW_C: begin
        cmd.rd_sel = RD_TAP;
        cmd.cap_lo = 1'b1;
        state_next = S_TW_D;
      end
      S_TW_D: begin
        cmd.tw_wr  = 1'b1;
        state_next = stat.k_last ? S_DR_RD : S_TW_A;
      end
      S_DR_RD: begin
        cmd.rd_sel = RD_IDX;
        state_next = S_DR_CAP;
      end
      S_DR_CAP: begin
        cmd.draw_cap = 1'b1;
        state_next   = (stat.cur_kind == REQ_RANGE) ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/mersenne_twister_generator.sv
// MT19937 generator, one request word in and one result word out at a time.
// After reset the 624-word state is seeded with 5489, a multiply and a write per
// word, before the request channel shows ready. A plain draw goes from accept
// through S_DR_RD and S_DR_CAP to the result; every 624th draw first twists the
// whole state word by word in S_TW_A to S_TW_D, bounded by the single read port of
// the state memory. A range draw adds a bit-serial remainder in S_DIV. A reseed
// reruns the seeding with its seed; mode 3 and a zero range bound answer 0 next.
// Depends on mtg_pkg, mtg_in_if, mtg_out_if, mtg_ctrl, mtg_datapath.
module mersenne_twister_generator
  import mtg_pkg::*;
(
  input logic       clk,
  input logic       rst,
  mtg_in_if.sink    req,
  mtg_out_if.source rsp
);

  mtg_cmd_t  cmd;
  mtg_stat_t stat;

  mtg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mtg_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (req.mode),
    .seed_value (req.seed_value),
    .range_max  (req.range_max),
    .value      (rsp.value)
  );

endmodule

>>> hw/rtl/mtg_checker.sv
// Port-level checks of the MT19937 generator, bound to the top level.
// Depends on mtg_pkg and mersenne_twister_generator_macros.svh.
`include "mersenne_twister_generator_macros.svh"

module mtg_checker
  import mtg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  mode,
  input logic [31:0] range_max,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value
);

  logic in_acc;
  logic out_acc;
  logic zero_req;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign zero_req = (mode == MODE_NOP) || ((mode == MODE_RANGE) && (range_max == 32'd0));

  // one request in flight: no new word while a result waits
  `MTG_ASSERT_NOW(a_no_overlap, !(in_ready && out_valid), "ready while result pending")
  `MTG_ASSERT_NEXT(a_one_result, out_acc, !out_valid && in_ready, "result repeated")
  `MTG_ASSERT_NEXT(a_zero_fast, in_acc && zero_req, out_valid && value == 32'd0,
                   "zero answer late or wrong")
  `MTG_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(value),
                   "stalled result changed")

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .mode      (req.mode),
  .range_max (req.range_max),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .value     (rsp.value)
);

>>> tb/mersenne_twister_generator_test.sv
// Self-checking bench for the MT19937 generator: predicts each result word
// and compares it with what the block returns over the response channel.
// Depends on mtg_pkg, mtg_in_if, mtg_out_if and mersenne_twister_generator.
`timescale 1ns / 100ps

module mersenne_twister_generator_test;
  import mtg_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mtg_in_if  req ();
  mtg_out_if rsp ();

  mersenne_twister_generator u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [31:0] mt_words [STATE_WORDS];
  int          mt_pos;
  logic [31:0] pending_values [$];

  int error_count = 0;
  int idle_cycles = 0;
  int results_seen = 0;
  bit long_stall_mode = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  function automatic void mt_seed(input logic [31:0] seed);
    logic [31:0] prev;
    mt_words[0] = seed;
    for (int k = 1; k < STATE_WORDS; k++) begin
      prev = mt_words[k - 1];
      mt_words[k] = SEED_MULT * (prev ^ (prev >> 30)) + k;
    end
    mt_pos = STATE_WORDS;
  endfunction

  function automatic logic [31:0] mt_next_word();
    logic [31:0] mix, nw, t;
    if (mt_pos >= STATE_WORDS) begin
      for (int k = 0; k < STATE_WORDS; k++) begin
        mix = (mt_words[k] & 32'h8000_0000) |
              (mt_words[(k + 1) % STATE_WORDS] & 32'h7FFF_FFFF);
        nw = mt_words[(k + TAP_OFFSET) % STATE_WORDS] ^ (mix >> 1);
        if (mix[0]) begin
          nw = nw ^ TWIST_MATRIX;
        end
        mt_words[k] = nw;
      end
      mt_pos = 0;
    end
    t = mt_words[mt_pos];
    mt_pos++;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  function automatic logic [31:0] mt_predict(input logic [1:0] mode,
                                             input logic [31:0] seed,
                                             input logic [31:0] bound);
    logic [31:0] r;
    r = 32'd0;
    if (mode == MODE_DRAW) begin
      r = mt_next_word();
    end else if (mode == MODE_RANGE) begin
      if (bound != 32'd0) begin
        r = mt_next_word() % bound;
      end
    end else if (mode == MODE_SEED) begin
      mt_seed(seed);
    end
    return r;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  initial begin
    req.valid      = 1'b0;
    req.mode       = MODE_DRAW;
    req.seed_value = '0;
    req.range_max  = '0;
    rsp.ready      = 1'b0;
  end

  // send one word; predict it on acceptance; valid stays up when no gap follows
  task automatic send_word(input logic [1:0] mode, input logic [31:0] seed,
                           input logic [31:0] bound);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.mode       <= mode;
    req.seed_value <= seed;
    req.range_max  <= bound;
    do @(posedge clk); while (!(req.ready === 1'b1));
    pending_values.push_back(mt_predict(mode, seed, bound));
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  // result checker with random backpressure
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (pending_values.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected word %h", rsp.value);
        end else begin
          want = pending_values.pop_front();
          if (rsp.value !== want) begin
            error_count++;
            if (error_count <= 10)
              $display("value mismatch: expected %h got %h", want, rsp.value);
          end
        end
      end
      if (long_stall_mode) rsp.ready <= ($urandom_range(0, 15) == 0);
      else rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic test_draw_edges();
    send_word(MODE_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_DRAW, 32'd0, 32'd0);
    send_word(MODE_RANGE, 32'd0, 32'd1);
    send_word(MODE_RANGE, 32'd0, 32'hFFFF_FFFF);
    send_word(MODE_RANGE, 32'd0, 32'h8000_0000);
    send_word(MODE_RANGE, 32'd0, 32'd7);
    // zero bound consumes nothing
    send_word(MODE_RANGE, 32'hFFFF_FFFF, 32'd0);
    send_word(MODE_DRAW, 32'd0, 32'd0);
    // unused mode is a no-op
    send_word(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_DRAW, 32'd0, 32'd0);
  endtask

  task automatic test_reseed_edges();
    send_word(MODE_SEED, 32'd0, 32'hFFFF_FFFF);
    send_word(MODE_DRAW, 32'd0, 32'd0);
    send_word(MODE_SEED, 32'hFFFF_FFFF, 32'd0);
    send_word(MODE_RANGE, 32'd0, 32'd1000);
    send_word(MODE_SEED, DEFAULT_SEED, 32'd0);
    send_word(MODE_DRAW, 32'd0, 32'd0);
  endtask

  // run of plain draws with long receiver stalls
  task automatic test_twist_wrap();
    wait_drained();
    long_stall_mode = 1;
    for (int i = 0; i < 40; i++) send_word(MODE_DRAW, 32'd0, 32'd0);
    wait_drained();
    long_stall_mode = 0;
  endtask

  task automatic test_random_mix();
    int roll;
    logic [31:0] bound;
    for (int i = 0; i < 600; i++) begin
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: bound = $urandom_range(1, 16);
        1: bound = 32'd0;
        default: bound = $urandom();
      endcase
      if (roll < 60) send_word(MODE_DRAW, $urandom(), $urandom());
      else if (roll < 90) send_word(MODE_RANGE, $urandom(), bound);
      else if (roll < 93) send_word(MODE_SEED, $urandom(), $urandom());
      else send_word(MODE_NOP, $urandom(), $urandom());
      if (i == 300) wait_drained();
    end
  endtask

  initial begin
    mt_seed(DEFAULT_SEED);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_draw_edges();
    test_reseed_edges();
    test_twist_wrap();
    test_random_mix();
    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
